>>> sv/nkm_pkg.sv
// Shared types and constants of the nearest-first k-way merge.
package nkm_pkg;

  localparam int MAX_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 64;
  localparam int COORD_BITS     = 16;

  localparam int POS_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int LIST_W   = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int OFFSET_W = 25;
  localparam int DIST_W   = 2 * COORD_BITS + 2;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LIST_W-1:0]   list;
    logic [DIST_W-1:0]   sq_dist;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic                  found;
    logic [LIST_W-1:0]     list;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    count;
    logic [OFFSET_W-1:0]   offset;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_SCAN,
    B_DRAIN,
    B_EMIT
  } back_state_t;

endpackage

>>> sv/nkm_front.sv
// Front end: takes input words, holds the camera point, computes squared distance.
module nkm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      opcode,
  input  logic [nkm_pkg::LIST_W-1:0]      list_index,
  input  logic [nkm_pkg::POS_W-1:0]       pos_x,
  input  logic [nkm_pkg::POS_W-1:0]       pos_y,
  input  logic [nkm_pkg::POS_W-1:0]       pos_z,
  input  logic [nkm_pkg::COUNT_W-1:0]     vertex_count,
  input  logic                            cfg_valid,
  input  logic [nkm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nkm_pkg::POS_W-1:0]       cfg_data,
  output logic                            q_push,
  output nkm_pkg::cmd_t                   q_data,
  input  logic                            q_full
);

  localparam int C = nkm_pkg::COORD_BITS;

  nkm_pkg::front_state_t state, state_next;

  logic [C-1:0] camera_x, camera_y, camera_z;

  logic signed [nkm_pkg::DIFF_W-1:0] diff [3];
  logic signed [nkm_pkg::DIFF_W-1:0] in_diff [3];
  logic [1:0]                        k;
  logic [nkm_pkg::DIST_W-1:0]        prod;
  logic [nkm_pkg::DIST_W-1:0]        acc;
  nkm_pkg::op_t                      op;
  logic [nkm_pkg::LIST_W-1:0]        list;
  logic [nkm_pkg::COUNT_W-1:0]       count;
  logic                              accept;
  logic signed [nkm_pkg::DIST_W-1:0] sq;

  assign accept = push && (state == nkm_pkg::F_IDLE);

  always_comb begin
    in_diff[0] = $signed({pos_x[C-1], pos_x[C-1:0]}) - $signed({camera_x[C-1], camera_x});
    in_diff[1] = $signed({pos_y[C-1], pos_y[C-1:0]}) - $signed({camera_y[C-1], camera_y});
    in_diff[2] = $signed({pos_z[C-1], pos_z[C-1:0]}) - $signed({camera_z[C-1], camera_z});
  end

  assign sq = diff[k] * diff[k];

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nkm_pkg::REG_CAMERA_X: camera_x <= cfg_data[C-1:0];
        nkm_pkg::REG_CAMERA_Y: camera_y <= cfg_data[C-1:0];
        nkm_pkg::REG_CAMERA_Z: camera_z <= cfg_data[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nkm_pkg::F_IDLE: begin
        if (push) begin
          case (opcode)
            nkm_pkg::OP_LOAD:  state_next = nkm_pkg::F_MUL;
            nkm_pkg::OP_NEXT,
            nkm_pkg::OP_CLEAR: state_next = nkm_pkg::F_PUSH;
            default:           state_next = nkm_pkg::F_IDLE;
          endcase
        end
      end
      nkm_pkg::F_MUL: if (k == 2'd2) state_next = nkm_pkg::F_SUM;
      nkm_pkg::F_SUM: state_next = nkm_pkg::F_PUSH;
      nkm_pkg::F_PUSH: if (!q_full) state_next = nkm_pkg::F_IDLE;
      default: state_next = nkm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != nkm_pkg::F_IDLE);
    q_push = (state == nkm_pkg::F_PUSH) && !q_full;
    q_data = '{op: op, list: list, sq_dist: acc, count: count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nkm_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one square per cycle, each added to the sum in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= nkm_pkg::op_t'(opcode);
      list  <= list_index;
      count <= vertex_count;
      diff  <= in_diff;
      k     <= 2'd0;
      prod  <= '0;
      acc   <= '0;
    end else if (state == nkm_pkg::F_MUL) begin
      prod <= sq;
      acc  <= acc + prod;
      k    <= k + 2'd1;
    end else if (state == nkm_pkg::F_SUM) begin
      acc <= acc + prod;
    end
  end

endmodule

>>> sv/nkm_queue.sv
// Short command queue between the front end and the merge engine.
module nkm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  nkm_pkg::cmd_t wdata,
  output logic          q_full,
  input  logic          rd,
  output nkm_pkg::cmd_t rdata,
  output logic          q_empty
);

  localparam int PW = nkm_pkg::QPTR_W;

  nkm_pkg::cmd_t entries [nkm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   level;
  logic          do_wr, do_rd;

  assign q_full  = (level == (PW+1)'(nkm_pkg::QUEUE_DEPTH));
  assign q_empty = (level == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) begin
        level <= level + 1'b1;
      end else if (do_rd && !do_wr) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wptr] <= wdata;
  end

endmodule

>>> sv/nkm_back.sv
// Merge engine: list stores, head scan, result register.
module nkm_back #(
  parameter int MAX_LISTS  = nkm_pkg::MAX_LISTS_DEF,
  parameter int LIST_DEPTH = nkm_pkg::LIST_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  nkm_pkg::cmd_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output nkm_pkg::res_t res
);

  localparam int LI_W  = $clog2(MAX_LISTS);
  localparam int RP_W  = $clog2(LIST_DEPTH + 1);
  localparam int AW    = $clog2(MAX_LISTS * LIST_DEPTH);
  localparam int MEM_W = nkm_pkg::DIST_W + nkm_pkg::COUNT_W;

  nkm_pkg::back_state_t state, state_next;

  logic [RP_W-1:0] fill [MAX_LISTS];
  logic [RP_W-1:0] rp   [MAX_LISTS];
  logic [nkm_pkg::OFFSET_W-1:0] total;

  logic [MEM_W-1:0] mem [MAX_LISTS * LIST_DEPTH];
  logic [MEM_W-1:0] rdata;
  logic [AW-1:0]    waddr, raddr;
  logic             mem_we;

  nkm_pkg::cmd_t  cmd;
  logic [LI_W-1:0] cmd_li;
  logic            cmd_ok;
  logic [LI_W+nkm_pkg::LIST_W-1:0] list_ext;

  logic [LI_W-1:0] scan_i;
  logic            scan_last;
  logic            issue_v;
  logic            pend_v;
  logic [LI_W-1:0] pend_li;
  logic [RP_W-1:0] pend_rp;

  logic                        have;
  logic [LI_W-1:0]             best_li;
  logic [RP_W-1:0]             best_rp;
  logic [nkm_pkg::DIST_W-1:0]  best_d;
  logic [nkm_pkg::COUNT_W-1:0] best_cnt;
  logic [nkm_pkg::DIST_W-1:0]  rd_dist;
  logic                        take;

  logic        out_valid;
  logic        out_free;
  logic        emit;
  logic        compare;
  logic [LI_W+nkm_pkg::LIST_W-1:0]   best_ext;
  logic [RP_W+nkm_pkg::SLOT_OUT_W-1:0] slot_ext;

  function automatic logic [AW-1:0] addr_of(input logic [LI_W-1:0] l, input logic [RP_W-1:0] s);
    addr_of = AW'(AW'(l) * AW'(LIST_DEPTH) + AW'(s));
  endfunction

  assign list_ext  = {{LI_W{1'b0}}, cmd.list};
  assign cmd_li    = list_ext[LI_W-1:0];
  assign cmd_ok    = (32'(cmd.list) < MAX_LISTS) && (32'(fill[cmd_li]) < LIST_DEPTH);
  assign scan_last = (32'(scan_i) == MAX_LISTS - 1);
  assign issue_v   = (rp[scan_i] < fill[scan_i]);
  assign rd_dist   = rdata[MEM_W-1 -: nkm_pkg::DIST_W];
  assign take      = pend_v && (!have || (rd_dist < best_d));
  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign best_ext  = {{nkm_pkg::LIST_W{1'b0}}, best_li};
  assign slot_ext  = {{nkm_pkg::SLOT_OUT_W{1'b0}}, best_rp};
  assign waddr     = addr_of(cmd_li, fill[cmd_li]);
  assign raddr     = addr_of(scan_i, rp[scan_i]);

  always_comb begin
    state_next = state;
    case (state)
      nkm_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            nkm_pkg::OP_LOAD: state_next = nkm_pkg::B_LOAD;
            nkm_pkg::OP_NEXT: state_next = nkm_pkg::B_SCAN;
            default:          state_next = nkm_pkg::B_IDLE;
          endcase
        end
      end
      nkm_pkg::B_LOAD:  state_next = nkm_pkg::B_IDLE;
      nkm_pkg::B_SCAN:  if (scan_last) state_next = nkm_pkg::B_DRAIN;
      nkm_pkg::B_DRAIN: state_next = nkm_pkg::B_EMIT;
      nkm_pkg::B_EMIT:  if (out_free) state_next = nkm_pkg::B_IDLE;
      default:          state_next = nkm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (state == nkm_pkg::B_IDLE) && !q_empty;
    mem_we  = (state == nkm_pkg::B_LOAD) && cmd_ok;
    compare = (state == nkm_pkg::B_SCAN) || (state == nkm_pkg::B_DRAIN);
    emit    = (state == nkm_pkg::B_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nkm_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= {cmd.sq_dist, cmd.count};
    rdata <= mem[raddr];
  end

  // list bookkeeping and running offset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        fill[i] <= '0;
        rp[i]   <= '0;
      end
      total <= '0;
    end else if (q_pop && (q_data.op == nkm_pkg::OP_CLEAR)) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        fill[i] <= '0;
        rp[i]   <= '0;
      end
      total <= '0;
    end else if (mem_we) begin
      fill[cmd_li] <= fill[cmd_li] + 1'b1;
    end else if (emit && have) begin
      rp[best_li] <= rp[best_li] + 1'b1;
      total       <= total + nkm_pkg::OFFSET_W'(best_cnt);
    end
  end

  // head scan: issue one read per cycle, compare the word read in the previous cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_data;
      scan_i <= '0;
      pend_v <= 1'b0;
      have   <= 1'b0;
    end else if (compare) begin
      pend_v  <= (state == nkm_pkg::B_SCAN) && issue_v;
      pend_li <= scan_i;
      pend_rp <= rp[scan_i];
      if (state == nkm_pkg::B_SCAN) scan_i <= scan_i + 1'b1;
      if (take) begin
        have     <= 1'b1;
        best_li  <= pend_li;
        best_rp  <= pend_rp;
        best_d   <= rd_dist;
        best_cnt <= rdata[nkm_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (have) begin
        res <= '{found: 1'b1, list: best_ext[nkm_pkg::LIST_W-1:0],
                 slot: slot_ext[nkm_pkg::SLOT_OUT_W-1:0], count: best_cnt, offset: total};
      end else begin
        res <= '0;
      end
    end
  end

endmodule

>>> sv/nearest_first_kway_merge.sv
// Top level of the nearest-first k-way merge.
// Input words enter through push/full and carry an opcode: load appends an
// item with its squared distance to the camera point to one list, next picks
// the nearest list head (lower list on a tie), clear empties all lists.
// Only next produces a result word, read through empty/pop; its fields give
// the chosen list, slot, vertex count and the running vertex offset, or
// found low when every list is exhausted. Opcode 3 is dropped.
// The camera point is written through cfg_valid/cfg_ready (index 0..2 for
// x, y, z); cfg_ready is always high; write it only while the block is idle.
// The front end holds full high while it works on a word: in F_PUSH on next or
// clear, and in F_MUL, F_SUM and F_PUSH on a load, where one multiplier forms
// the three squares in turn. A four-entry queue feeds the merge engine, which
// writes a load in B_LOAD; on a next one list head is read from the store and
// compared per cycle in B_SCAN. With the result register full the engine holds
// the finished word in B_EMIT until pop, and the queue then fills and
// raises full. Reset empties all lists, the queue and the result register,
// zeroes the running offset and the camera point; the stores need no clearing.
module nearest_first_kway_merge #(
  parameter int MAX_LISTS  = nkm_pkg::MAX_LISTS_DEF,
  parameter int LIST_DEPTH = nkm_pkg::LIST_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       opcode,
  input  logic [nkm_pkg::LIST_W-1:0]       list_index,
  input  logic [nkm_pkg::POS_W-1:0]        pos_x,
  input  logic [nkm_pkg::POS_W-1:0]        pos_y,
  input  logic [nkm_pkg::POS_W-1:0]        pos_z,
  input  logic [nkm_pkg::COUNT_W-1:0]      vertex_count,
  output logic                             empty,
  input  logic                             pop,
  output logic                             found,
  output logic [nkm_pkg::LIST_W-1:0]       chosen_list,
  output logic [nkm_pkg::SLOT_OUT_W-1:0]   chosen_slot,
  output logic [nkm_pkg::COUNT_W-1:0]      chosen_count,
  output logic [nkm_pkg::OFFSET_W-1:0]     vertex_offset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nkm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nkm_pkg::POS_W-1:0]        cfg_data
);

  nkm_pkg::cmd_t fq_data, qb_data;
  nkm_pkg::res_t res;
  logic          fq_push, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  nkm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .list_index   (list_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .vertex_count (vertex_count),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_push       (fq_push),
    .q_data       (fq_data),
    .q_full       (q_full)
  );

  nkm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wdata   (fq_data),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (qb_data),
    .q_empty (q_empty)
  );

  nkm_back #(
    .MAX_LISTS  (MAX_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (qb_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign found         = res.found;
  assign chosen_list   = res.list;
  assign chosen_slot   = res.slot;
  assign chosen_count  = res.count;
  assign vertex_offset = res.offset;

endmodule

>>> dv/nearest_first_kway_merge_tb.sv
// Self-checking testbench for the nearest-first k-way merge: random and directed words.
`timescale 1ns / 100ps

module nearest_first_kway_merge_tb;

  localparam int NUM_LISTS      = nkm_pkg::MAX_LISTS_DEF;
  localparam int LIST_SLOTS     = nkm_pkg::LIST_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [nkm_pkg::LIST_W-1:0]  li;
    logic [nkm_pkg::POS_W-1:0]   x;
    logic [nkm_pkg::POS_W-1:0]   y;
    logic [nkm_pkg::POS_W-1:0]   z;
    logic [nkm_pkg::COUNT_W-1:0] cnt;
  } stim_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic [1:0]                     opcode = nkm_pkg::OP_LOAD;
  logic [nkm_pkg::LIST_W-1:0]     list_index = '0;
  logic [nkm_pkg::POS_W-1:0]      pos_x = '0;
  logic [nkm_pkg::POS_W-1:0]      pos_y = '0;
  logic [nkm_pkg::POS_W-1:0]      pos_z = '0;
  logic [nkm_pkg::COUNT_W-1:0]    vertex_count = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic                           found;
  logic [nkm_pkg::LIST_W-1:0]     chosen_list;
  logic [nkm_pkg::SLOT_OUT_W-1:0] chosen_slot;
  logic [nkm_pkg::COUNT_W-1:0]    chosen_count;
  logic [nkm_pkg::OFFSET_W-1:0]   vertex_offset;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [nkm_pkg::CFG_IDX_W-1:0]  cfg_index = nkm_pkg::REG_CAMERA_X;
  logic [nkm_pkg::POS_W-1:0]      cfg_data = '0;

  nearest_first_kway_merge dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .list_index(list_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .vertex_count(vertex_count),
    .empty(empty), .pop(pop),
    .found(found), .chosen_list(chosen_list), .chosen_slot(chosen_slot),
    .chosen_count(chosen_count), .vertex_offset(vertex_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow of the merge state
  logic [nkm_pkg::DIST_W-1:0]   head_dist [NUM_LISTS*LIST_SLOTS];
  logic [nkm_pkg::COUNT_W-1:0]  head_count [NUM_LISTS*LIST_SLOTS];
  int                           fill_cnt [NUM_LISTS];
  int                           read_ptr [NUM_LISTS];
  logic [nkm_pkg::OFFSET_W-1:0] offset_sum;
  logic signed [nkm_pkg::POS_W-1:0] cam_x, cam_y, cam_z;

  stim_word_t    stim_q[$];
  nkm_pkg::res_t expected_picks[$];

  logic [nkm_pkg::POS_W-1:0] gen_cam [3];
  bit  in_fire = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  int  errors = 0;
  int  words_in = 0;
  int  picks_checked = 0;
  int  empty_picks = 0;
  int  dropped_loads = 0;
  int  camera_settings = 0;

  function automatic logic [nkm_pkg::DIST_W-1:0] camera_distance(
      logic [nkm_pkg::POS_W-1:0] px, logic [nkm_pkg::POS_W-1:0] py,
      logic [nkm_pkg::POS_W-1:0] pz);
    longint dx, dy, dz;
    dx = longint'($signed(px)) - longint'(cam_x);
    dy = longint'($signed(py)) - longint'(cam_y);
    dz = longint'($signed(pz)) - longint'(cam_z);
    return nkm_pkg::DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  task automatic merge_step(input logic [1:0] op, input logic [nkm_pkg::LIST_W-1:0] li,
                            input logic [nkm_pkg::POS_W-1:0] px,
                            input logic [nkm_pkg::POS_W-1:0] py,
                            input logic [nkm_pkg::POS_W-1:0] pz,
                            input logic [nkm_pkg::COUNT_W-1:0] cnt);
    int slot, addr, best, i;
    bit have;
    logic [nkm_pkg::DIST_W-1:0] best_d, d;
    nkm_pkg::res_t pick;
    case (op)
      nkm_pkg::OP_LOAD: begin
        slot = fill_cnt[li];
        if (int'(li) < NUM_LISTS && slot < LIST_SLOTS) begin
          addr = int'(li) * LIST_SLOTS + slot;
          head_dist[addr] = camera_distance(px, py, pz);
          head_count[addr] = cnt;
          fill_cnt[li] = slot + 1;
        end else begin
          dropped_loads++;
        end
      end
      nkm_pkg::OP_NEXT: begin
        have = 0;
        best = 0;
        best_d = '0;
        for (i = 0; i < NUM_LISTS; i++) begin
          if (read_ptr[i] < fill_cnt[i]) begin
            d = head_dist[i * LIST_SLOTS + read_ptr[i]];
            if (!have || d < best_d) begin
              have = 1;
              best = i;
              best_d = d;
            end
          end
        end
        pick = '0;
        if (have) begin
          addr = best * LIST_SLOTS + read_ptr[best];
          pick.found = 1'b1;
          pick.list = nkm_pkg::LIST_W'(best);
          pick.slot = nkm_pkg::SLOT_OUT_W'(read_ptr[best]);
          pick.count = head_count[addr];
          pick.offset = offset_sum;
          offset_sum = offset_sum + nkm_pkg::OFFSET_W'(head_count[addr]);
          read_ptr[best]++;
        end
        expected_picks = {expected_picks, pick};
      end
      nkm_pkg::OP_CLEAR: begin
        for (i = 0; i < NUM_LISTS; i++) begin
          fill_cnt[i] = 0;
          read_ptr[i] = 0;
        end
        offset_sum = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    bit activity;
    nkm_pkg::res_t want;
    if (!rst) begin
      activity = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nkm_pkg::REG_CAMERA_X: cam_x = cfg_data;
          nkm_pkg::REG_CAMERA_Y: cam_y = cfg_data;
          nkm_pkg::REG_CAMERA_Z: cam_z = cfg_data;
          default: ;
        endcase
        activity = 1;
      end
      if (pop && !empty) begin
        activity = 1;
        if (expected_picks.size() == 0) begin
          $display("%0t: result word with no expectation waiting, got found=%0d list=%0d",
                   $time, found, chosen_list);
          errors++;
        end else begin
          want = expected_picks.pop_front();
          check_field("found", want.found, found);
          check_field("chosen_list", want.list, chosen_list);
          check_field("chosen_slot", want.slot, chosen_slot);
          check_field("chosen_count", want.count, chosen_count);
          check_field("vertex_offset", want.offset, vertex_offset);
          picks_checked++;
          if (!want.found) empty_picks++;
        end
      end
      if (push && !full) begin
        merge_step(opcode, list_index, pos_x, pos_y, pos_z, vertex_count);
        in_fire = 1;
        words_in++;
        activity = 1;
      end
      idle_cycles = activity ? 0 : idle_cycles + 1;
    end
  end

  // Driver: bursts of words with random gaps; no gaps while the receiver holds off
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    if (in_fire) begin
      void'(stim_q.pop_front());
      in_fire = 0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    if (!rst && gap_left > 0 && hold_left == 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (rst || stim_q.size() == 0) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      opcode <= stim_q[0].op;
      list_index <= stim_q[0].li;
      pos_x <= stim_q[0].x;
      pos_y <= stim_q[0].y;
      pos_z <= stim_q[0].z;
      vertex_count <= stim_q[0].cnt;
    end
  end

  // Receiver: stall patterns, each picked at random and held for a random span
  int pop_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ((stall_tick % 5) < 2);
        default: pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic add_item(input logic [1:0] op, input logic [nkm_pkg::LIST_W-1:0] li,
                          input logic [nkm_pkg::POS_W-1:0] px,
                          input logic [nkm_pkg::POS_W-1:0] py,
                          input logic [nkm_pkg::POS_W-1:0] pz,
                          input logic [nkm_pkg::COUNT_W-1:0] cnt);
    stim_word_t w;
    w.op = op;
    w.li = li;
    w.x = px;
    w.y = py;
    w.z = pz;
    w.cnt = cnt;
    stim_q = {stim_q, w};
  endtask

  // Word whose fields other than the opcode are random
  task automatic add_noise(input logic [1:0] op);
    add_item(op, nkm_pkg::LIST_W'($urandom), nkm_pkg::POS_W'($urandom),
             nkm_pkg::POS_W'($urandom), nkm_pkg::POS_W'($urandom),
             nkm_pkg::COUNT_W'($urandom));
  endtask

  task automatic write_reg(input logic [nkm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nkm_pkg::POS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_camera(input logic [nkm_pkg::POS_W-1:0] cx,
                              input logic [nkm_pkg::POS_W-1:0] cy,
                              input logic [nkm_pkg::POS_W-1:0] cz);
    write_reg(nkm_pkg::REG_CAMERA_X, cx);
    write_reg(nkm_pkg::REG_CAMERA_Y, cy);
    write_reg(nkm_pkg::REG_CAMERA_Z, cz);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_cam[0] = cx;
    gen_cam[1] = cy;
    gen_cam[2] = cz;
    camera_settings++;
  endtask

  task automatic write_rand_camera();
    write_camera(nkm_pkg::POS_W'($urandom), nkm_pkg::POS_W'($urandom),
                 nkm_pkg::POS_W'($urandom));
  endtask

  // Wait until every word is in and every result is out, then let the engine settle
  task automatic finish_phase();
    while (stim_q.size() != 0 || expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly near the camera so that distances tie often
  function automatic logic [nkm_pkg::POS_W-1:0] rand_coord(
      input logic [nkm_pkg::POS_W-1:0] c);
    logic [nkm_pkg::POS_W-1:0] v;
    if ($urandom_range(0, 2) == 0) v = nkm_pkg::POS_W'($urandom);
    else v = c + nkm_pkg::POS_W'($urandom_range(0, 6)) - nkm_pkg::POS_W'(3);
    return v;
  endfunction

  function automatic logic [nkm_pkg::COUNT_W-1:0] rand_count();
    logic [nkm_pkg::COUNT_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '1;
      1: v = '0;
      default: v = nkm_pkg::COUNT_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_rand_load(input logic [nkm_pkg::LIST_W-1:0] li,
                               input logic [nkm_pkg::COUNT_W-1:0] cnt);
    add_item(nkm_pkg::OP_LOAD, li, rand_coord(gen_cam[0]), rand_coord(gen_cam[1]),
             rand_coord(gen_cam[2]), cnt);
  endtask

  // Rounds of loads followed by about as many nexts, with clears and noise mixed in
  task automatic gen_mixed(input int budget);
    int made, roll, k, nl, lo, j;
    made = 0;
    while (made < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        add_noise(OP_UNUSED);
      end else if (roll < 9) begin
        add_noise(nkm_pkg::OP_CLEAR);
        made++;
      end else if (roll < 12) begin
        add_noise(nkm_pkg::OP_NEXT);
        made++;
      end else begin
        k = $urandom_range(1, 10);
        lo = $urandom_range(0, NUM_LISTS - 1);
        nl = $urandom_range(1, NUM_LISTS);
        repeat (k)
          add_rand_load(nkm_pkg::LIST_W'((lo + $urandom_range(0, nl - 1)) % NUM_LISTS),
                        rand_count());
        j = k + $urandom_range(0, 2) - 1;
        repeat (j) add_noise(nkm_pkg::OP_NEXT);
        made += k + j;
      end
    end
  endtask

  initial begin
    int r, l;
    for (l = 0; l < NUM_LISTS; l++) begin
      fill_cnt[l] = 0;
      read_ptr[l] = 0;
    end
    offset_sum = '0;
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lists, ignored opcode, extremes, ties, clear
    write_camera(16'h0000, 16'h0000, 16'h0000);
    add_item(nkm_pkg::OP_NEXT, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_item(OP_UNUSED, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_item(nkm_pkg::OP_LOAD, 3'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    add_item(nkm_pkg::OP_LOAD, 3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    add_item(nkm_pkg::OP_LOAD, 3'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_item(nkm_pkg::OP_LOAD, 3'd5, 16'h0001, 16'h0000, 16'h0000, 16'h0005);
    add_item(nkm_pkg::OP_LOAD, 3'd2, 16'h0000, 16'hffff, 16'h0000, 16'h0007);
    add_item(nkm_pkg::OP_LOAD, 3'd3, 16'h0000, 16'h0000, 16'h0001, 16'h0009);
    repeat (7) add_item(nkm_pkg::OP_NEXT, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_item(nkm_pkg::OP_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_item(nkm_pkg::OP_NEXT, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_item(nkm_pkg::OP_LOAD, 3'd4, 16'h1234, 16'hedcb, 16'h0042, 16'h0003);
    add_item(nkm_pkg::OP_NEXT, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    finish_phase();

    write_camera(16'h8000, 16'h7fff, 16'h8000);
    add_item(nkm_pkg::OP_LOAD, 3'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    add_item(nkm_pkg::OP_LOAD, 3'd6, 16'h8000, 16'h7fff, 16'h8000, 16'h0002);
    repeat (3) add_item(nkm_pkg::OP_NEXT, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_item(nkm_pkg::OP_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    finish_phase();

    // Random phases; the second one holds the receiver off so the block backs up
    write_rand_camera();
    gen_mixed(130);
    finish_phase();

    write_camera(16'h7fff, 16'h8000, 16'h7fff);
    hold_left = HOLD_CYCLES;
    gen_mixed(130);
    finish_phase();

    write_rand_camera();
    gen_mixed(130);
    finish_phase();

    // Fill every list past its depth with maximal counts, then drain past empty
    write_rand_camera();
    add_item(nkm_pkg::OP_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    for (r = 0; r < LIST_SLOTS + 6; r++)
      for (l = 0; l < NUM_LISTS; l++)
        add_rand_load(nkm_pkg::LIST_W'((l + r) % NUM_LISTS), 16'hffff);
    repeat (NUM_LISTS * LIST_SLOTS + 4) add_noise(nkm_pkg::OP_NEXT);
    finish_phase();

    write_camera(16'h8000, 16'h8000, 16'h8000);
    add_item(nkm_pkg::OP_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    gen_mixed(130);
    finish_phase();

    $display("Run covered %0d input words and %0d result words (%0d with every list empty),",
             words_in, picks_checked, empty_picks);
    $display("%0d loads dropped on full lists, %0d camera settings.",
             dropped_loads, camera_settings);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
